// ----- hw/rtl/swp_pkg.sv -----
// Shared types and constants for the smoothed window projection block.
`default_nettype none

package swp_pkg;

   // Default sizes of the coefficient store and the averaging history.
   localparam int MAX_FRAME_DEFAULT = 4096;
   localparam int MAX_AVG_DEFAULT   = 64;

   // Fixed field widths.
   localparam int SAMPLE_W    = 16;
   localparam int PROD_W      = 2 * SAMPLE_W;
   localparam int COEFF_IDX_W = 12;
   localparam int PROJ_W      = 48;
   localparam int FRAME_LEN_W = 13;
   localparam int AVG_LEN_W   = 7;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_IDX_W   = 1;

   // Control register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_LENGTH   = CSR_IDX_W'(1);

   // Control register reset values.
   localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = FRAME_LEN_W'(4096);
   localparam logic [AVG_LEN_W-1:0]   AVG_LEN_RESET   = AVG_LEN_W'(1);

   // Transaction kinds on the request channel.
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // Saturation limits of a smoothed sample.
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX  = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN  = 16'sh8000;
   localparam int                         SAT_NEG_MAG = 32768;

   // Controls from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic mul;
      logic acc;
      logic clear;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/swp_req_if.sv -----
// Request channel: coefficient loads and frame samples.
`default_nettype none

interface swp_req_if import swp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [COEFF_IDX_W-1:0]     coeff_index;
   logic signed [SAMPLE_W-1:0] value;

   modport source (output valid, output action, output coeff_index, output value,
                   input ready);
   modport sink   (input valid, input action, input coeff_index, input value,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swp_rsp_if.sv -----
// Response channel: one projection per completed frame.
`default_nettype none

interface swp_rsp_if import swp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [PROJ_W-1:0] projection;

   modport source (output valid, output projection, input ready);
   modport sink   (input valid, input projection, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/smoothed_window_projection.sv -----
// Top level: moving-average windowed dot product over frames of samples.
//
//   Channel   Direction  Carries
//   req_bus   in         action, coeff_index, value (load or sample)
//   rsp_bus   out        projection, one per completed frame
//   csr_*     in         frame_length (index 0), avg_length (index 1)
//
// Coefficient loads and samples are accepted only while the sequencer is idle. A
// sample then passes the read, divide and accumulate states; the divider works on
// SUM_W = 17 + clog2(MAX_FRAME) bits and produces one quotient bit per cycle.
// Reset is synchronous and clears the frame state; the coefficient and
// history memories are not cleared. A stalled response holds the next frame at
// its last sample; loads and earlier samples keep flowing until then.
`default_nettype none

module smoothed_window_projection import swp_pkg::*; #(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT,
   parameter int MAX_AVG   = MAX_AVG_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   swp_req_if.sink                    req_bus,
   swp_rsp_if.source                  rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int POS_W  = $clog2(MAX_FRAME);
   localparam int FLEN_W = $clog2(MAX_FRAME + 1);
   localparam int HIDX_W = (MAX_AVG > 1) ? $clog2(MAX_AVG) : 1;
   localparam int ALEN_W = $clog2(MAX_AVG + 1);
   localparam int SUM_W  = 17 + $clog2(MAX_FRAME);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_ACC
   } swp_state_type;

   swp_state_type              state_ff, state_in;
   logic [FRAME_LEN_W-1:0]     frame_len_ff, frame_len_in;
   logic [AVG_LEN_W-1:0]       avg_len_ff, avg_len_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [HIDX_W-1:0]          head_ff, head_in;
   logic [ALEN_W-1:0]          fill_ff, fill_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       grow_ff, grow_in;
   logic                       last_ff, last_in;
   logic                       div_start_ff, div_start_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [PROJ_W-1:0]   rsp_proj_ff, rsp_proj_in;

   // Coefficient and history memories with registered read data.
   logic signed [SAMPLE_W-1:0] coeff_mem [MAX_FRAME];
   logic signed [SAMPLE_W-1:0] hist_mem [MAX_AVG];
   logic signed [SAMPLE_W-1:0] coeff_rd_ff;
   logic signed [SAMPLE_W-1:0] hist_rd_ff;

   logic                       req_fire;
   logic                       sample_fire;
   logic                       coeff_we;
   logic                       coeff_ok;
   logic [POS_W-1:0]           coeff_waddr;
   logic                       hist_we;
   logic [FLEN_W-1:0]          flen_eff;
   logic [ALEN_W-1:0]          alen_eff;
   logic [ALEN_W-1:0]          head_wide;
   logic [ALEN_W-1:0]          tail_wide;
   logic [HIDX_W-1:0]          tail_idx;
   logic signed [SUM_W-1:0]    drop;
   mac_ctrl_type               mac_ctrl;
   logic signed [PROJ_W-1:0]   mac_total_next;
   logic                       div_done;
   logic signed [SAMPLE_W-1:0] div_avg;

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign req_fire           = req_bus.valid & req_bus.ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.projection = rsp_proj_ff;

   // Effective lengths: zero acts as one, large values clamp to the store size.
   always_comb begin
      if (frame_len_ff == '0) begin
         flen_eff = FLEN_W'(1);
      end else if (32'(frame_len_ff) > MAX_FRAME) begin
         flen_eff = FLEN_W'(MAX_FRAME);
      end else begin
         flen_eff = FLEN_W'(frame_len_ff);
      end
      if (avg_len_ff == '0) begin
         alen_eff = ALEN_W'(1);
      end else if (32'(avg_len_ff) > MAX_AVG) begin
         alen_eff = ALEN_W'(MAX_AVG);
      end else begin
         alen_eff = ALEN_W'(avg_len_ff);
      end
   end

   // History entry written avg_length samples ago, modulo the history depth.
   assign head_wide = ALEN_W'(head_ff);
   assign tail_wide = (head_wide >= alen_eff) ? head_wide - alen_eff
                                              : head_wide + ALEN_W'(MAX_AVG) - alen_eff;
   assign tail_idx  = HIDX_W'(tail_wide);

   // Coefficient loads beyond the store are dropped.
   assign coeff_ok    = (32'(req_bus.coeff_index) < MAX_FRAME);
   assign coeff_waddr = POS_W'(req_bus.coeff_index);

   // Sample leaving the window once it is full.
   assign drop = grow_ff ? '0 : SUM_W'(hist_rd_ff);

   // Sequencer and register writes.
   always_comb begin
      state_in     = state_ff;
      frame_len_in = frame_len_ff;
      avg_len_in   = avg_len_ff;
      pos_in       = pos_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      grow_in      = grow_ff;
      last_in      = last_ff;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_proj_in  = rsp_proj_ff;
      sample_fire  = 1'b0;
      coeff_we     = 1'b0;
      hist_we      = 1'b0;
      mac_ctrl     = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_LENGTH: frame_len_in = csr_wdata;
            CSR_AVG_LENGTH:   avg_len_in   = csr_wdata[AVG_LEN_W-1:0];
            default: ;
         endcase
      end

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.action == ACT_SAMPLE) begin
                  sample_fire = 1'b1;
                  sample_in   = req_bus.value;
                  grow_in     = (fill_ff < alen_eff);
                  last_in     = ((FLEN_W'(pos_ff) + FLEN_W'(1)) >= flen_eff);
                  state_in    = ST_READ;
               end else begin
                  coeff_we = coeff_ok;
               end
            end
         end
         ST_READ: begin
            // Update the running sum and record the new sample.
            sum_in       = sum_ff + SUM_W'(sample_ff) - drop;
            fill_in      = grow_ff ? fill_ff + ALEN_W'(1) : fill_ff;
            hist_we      = 1'b1;
            div_start_in = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               mac_ctrl.mul = 1'b1;
               state_in     = ST_ACC;
            end
         end
         ST_ACC: begin
            if (!last_ff) begin
               mac_ctrl.acc = 1'b1;
               pos_in       = pos_ff + POS_W'(1);
               head_in      = (head_ff == HIDX_W'(MAX_AVG - 1)) ? '0 : head_ff + HIDX_W'(1);
               state_in     = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_bus.ready) begin
               // Frame complete: publish the sum and restart the frame.
               rsp_valid_in   = 1'b1;
               rsp_proj_in    = mac_total_next;
               mac_ctrl.clear = 1'b1;
               pos_in         = '0;
               head_in        = '0;
               fill_in        = '0;
               sum_in         = '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_len_ff <= FRAME_LEN_RESET;
         avg_len_ff   <= AVG_LEN_RESET;
         pos_ff       <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_len_ff <= frame_len_in;
         avg_len_ff   <= avg_len_in;
         pos_ff       <= pos_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      grow_ff     <= grow_in;
      last_ff     <= last_in;
      rsp_proj_ff <= rsp_proj_in;
   end

   // Coefficient memory: written by loads, read at the sample position.
   always_ff @(posedge clock) begin
      if (coeff_we) begin
         coeff_mem[coeff_waddr] <= req_bus.value;
      end
      if (sample_fire) begin
         coeff_rd_ff <= coeff_mem[pos_ff];
      end
   end

   // History memory: the tail is read on acceptance, the head written in the read state.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[head_ff] <= sample_ff;
      end
      if (sample_fire) begin
         hist_rd_ff <= hist_mem[tail_idx];
      end
   end

   swp_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (ALEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_avg)
   );

   swp_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .sample     (div_avg),
      .coeff      (coeff_rd_ff),
      .total_next (mac_total_next)
   );

   // A response only appears when a frame's last sample completes.
   a_rsp_from_acc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_ACC)
      else $error("response raised outside the accumulate step");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished while the sequencer was not waiting");

   // A frame-end blocked by a pending response keeps its place.
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && last_ff && rsp_valid_ff && !rsp_bus.ready)
      |=> (state_ff == ST_ACC && rsp_valid_ff))
      else $error("frame end left while the response was stalled");

   // Counters stay within their stores.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_AVG && 32'(head_ff) < MAX_AVG)
      else $error("averaging counters out of range");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < MAX_FRAME)
      else $error("sample position out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/swp_div.sv -----
// Iterative signed divider that yields a saturated 16-bit moving average.
`default_nettype none

module swp_div import swp_pkg::*; #(
   parameter int DIVIDEND_W = 29,
   parameter int DIVISOR_W  = 7
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]         divisor,
   output logic                              done,
   output logic signed [SAMPLE_W-1:0]        quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } div_state_type;

   div_state_type                state_ff, state_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]         rem_ff, rem_in;
   logic [DIVIDEND_W-1:0]        quo_ff, quo_in;
   logic [DIVISOR_W-1:0]         dsr_ff, dsr_in;
   logic                         neg_ff, neg_in;
   logic                         done_ff, done_in;
   logic signed [SAMPLE_W-1:0]   quotient_ff, quotient_in;

   logic [DIVIDEND_W-1:0]        mag;
   logic [DIVISOR_W:0]           rem_sh;
   logic [DIVISOR_W:0]           trial;
   logic                         fits;
   logic signed [SAMPLE_W-1:0]   sat;

   // Magnitude of the dividend; the sign is applied after the last step.
   assign mag = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);

   // One restoring step: shift in the next dividend bit and try a subtract.
   assign rem_sh = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial  = rem_sh - {1'b0, dsr_ff};
   assign fits   = ~trial[DIVISOR_W];

   // Truncated quotient, signed and clamped to the sample range.
   always_comb begin
      if (neg_ff) begin
         if (quo_ff > DIVIDEND_W'(SAT_NEG_MAG)) begin
            sat = SAMPLE_MIN;
         end else begin
            sat = SAMPLE_W'(~quo_ff + DIVIDEND_W'(1));
         end
      end else begin
         if (quo_ff > DIVIDEND_W'(SAMPLE_MAX)) begin
            sat = SAMPLE_MAX;
         end else begin
            sat = SAMPLE_W'(quo_ff);
         end
      end
   end

   // Sequencing of the division: load, one quotient bit per cycle, finish.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dsr_in      = dsr_ff;
      neg_in      = neg_ff;
      done_in     = 1'b0;
      quotient_in = quotient_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = dividend[DIVIDEND_W-1];
               quo_in   = mag;
               rem_in   = '0;
               dsr_in   = divisor;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            rem_in = fits ? trial[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            quotient_in = sat;
            done_in     = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dsr_ff      <= dsr_in;
      neg_ff      <= neg_in;
      quotient_ff <= quotient_in;
   end

   assign done     = done_ff;
   assign quotient = quotient_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/swp_mac.sv -----
// Multiply-accumulate unit for the windowed frame sum.
`default_nettype none

module swp_mac import swp_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mac_ctrl_type               ctrl,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic signed [SAMPLE_W-1:0] coeff,
   output logic signed [PROJ_W-1:0]        total_next
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROJ_W-1:0] total_ff, total_in;

   // Frame total including the product that is waiting in the register.
   assign total_next = total_ff + PROJ_W'(prod_ff);

   always_comb begin
      total_in = total_ff;
      if (ctrl.clear) begin
         total_in = '0;
      end else if (ctrl.acc) begin
         total_in = total_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
      if (ctrl.mul) begin
         prod_ff <= sample * coeff;
      end
   end

endmodule

`default_nettype wire
